>>> hw/rtl/tlbfl_pkg.sv
// Shared types and constants of the FIFO/LRU translation buffer.
package tlbfl_pkg;

  localparam int unsigned DEF_ENTRIES = 16;
  localparam int unsigned PID_W       = 16;
  localparam int unsigned PAGE_W      = 20;
  localparam int unsigned FRAME_W     = 20;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic MODE_FIFO  = 1'b0;
  localparam logic MODE_LRU   = 1'b1;
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_ADD    = 1'b1;
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_CAP    = 1'b1;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              cmp_en;
    logic              upd_en;
    logic              mode;
    logic              dec_en;
    logic              evict;
    logic              promote;
    logic              append;
    logic [PID_W-1:0]  key_pid;
    logic [PAGE_W-1:0] key_page;
    entry_t            new_ent;
  } cell_ctrl_t;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] frame;
  } hit_chain_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] page;
  } vic_chain_t;

endpackage

>>> hw/rtl/tlb_fifo_lru_replacement_unit.sv
// Top level of the fully associative FIFO/LRU translation buffer.
//
// Input channel (in_valid/in_ready) carries lookup or add transactions; the
// result channel (out_valid/out_ready) returns exactly one result for each.
// A row of ENTRIES cells holds the entries in insertion order; each cell
// compares its key and passes first-match and victim data to the next cell.
// A transaction is compared when it is accepted, and the compare results are
// registered; the row is updated in the S_UPD state, which also loads the
// result register.
// One request is held at a time: a new transaction is accepted only after
// the row update of the previous one.
// When the receiver stalls, the finished result stays in the output register
// and the next transaction can still be accepted and compared; its update
// waits until the output register is free.
// Reset (rst_n, synchronous) empties the buffer, selects FIFO and sets
// capacity 0, which disables the buffer until capacity is written.
// Configuration is written through the APB-style cfg_ port: mode at byte 0,
// capacity at byte 4.
module tlb_fifo_lru_replacement_unit #(
  parameter int unsigned ENTRIES = tlbfl_pkg::DEF_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [tlbfl_pkg::PID_W-1:0]       in_proc_id,
  input  logic [tlbfl_pkg::PAGE_W-1:0]      in_page_num,
  input  logic [tlbfl_pkg::FRAME_W-1:0]     in_frame_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [tlbfl_pkg::FRAME_W-1:0]     out_frame_out,
  output logic                              out_evicted,
  output logic [tlbfl_pkg::PAGE_W-1:0]      out_evicted_page,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tlbfl_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tlbfl_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tlbfl_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import tlbfl_pkg::*;

  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  typedef enum logic {S_IDLE, S_UPD} state_t;

  logic             mode;
  logic [CAP_W-1:0] capacity;

  state_t state_r, state_nxt;
  logic   in_acc, upd_en;

  logic          req_type_r, en_r, hit_r;
  entry_t        req_ent_r;
  logic [FRAME_W-1:0] hit_frame_r;
  logic [RW-1:0] hit_rank_r, vic_rank_r;
  logic [PAGE_W-1:0]  vic_page_r;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_app;

  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_evicted_r, out_evicted_nxt;
  logic [PAGE_W-1:0]  out_epage_r, out_epage_nxt;

  logic is_lookup, evict, promote, append;
  cell_ctrl_t    ctrl;
  logic [RW-1:0] thr, promo_rank;

  hit_chain_t    hit_ch      [ENTRIES+1];
  logic [RW-1:0] hit_rank_ch [ENTRIES+1];
  vic_chain_t    vic_ch      [ENTRIES+1];
  logic [RW-1:0] vic_rank_ch [ENTRIES+1];
  logic          slot_valid  [ENTRIES+1];
  entry_t        slot_ent    [ENTRIES+1];
  logic [RW-1:0] slot_rank   [ENTRIES+1];

  tlbfl_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mode        (mode),
    .capacity    (capacity)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign upd_en   = (state_r == S_UPD) && (!out_valid_r || out_ready);

  assign is_lookup = (req_type_r == REQ_LOOKUP);
  assign evict     = en_r && !is_lookup && (cnt_r != '0) &&
                     ((CMPW'(cnt_r) >= CMPW'(capacity)) || (cnt_r == FULL));
  assign promote   = en_r && is_lookup && hit_r && (mode == MODE_LRU);
  assign append    = en_r && !is_lookup;
  assign cnt_app   = evict ? cnt_r - CW'(1) : cnt_r;
  assign thr       = promote ? hit_rank_r : vic_rank_r;
  assign promo_rank = RW'(cnt_r - CW'(1));

  always_comb begin
    ctrl.cmp_en   = in_acc;
    ctrl.upd_en   = upd_en;
    ctrl.mode     = mode;
    ctrl.dec_en   = upd_en && (promote || evict);
    ctrl.evict    = evict;
    ctrl.promote  = promote;
    ctrl.append   = append;
    ctrl.key_pid  = in_proc_id;
    ctrl.key_page = in_page_num;
    ctrl.new_ent  = req_ent_r;
  end

  assign hit_ch[0]      = '0;
  assign hit_rank_ch[0] = '0;
  assign vic_ch[0]      = '0;
  assign vic_rank_ch[0] = '0;
  // past the last slot there is nothing to shift in
  assign slot_valid[ENTRIES] = 1'b0;
  assign slot_ent[ENTRIES]   = '0;
  assign slot_rank[ENTRIES]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tlbfl_cell #(
      .IDX (g),
      .CW  (CW),
      .RW  (RW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .thr          (thr),
      .promo_rank   (promo_rank),
      .app_slot     (cnt_app),
      .hit_in       (hit_ch[g]),
      .hit_rank_in  (hit_rank_ch[g]),
      .vic_in       (vic_ch[g]),
      .vic_rank_in  (vic_rank_ch[g]),
      .hit_out      (hit_ch[g+1]),
      .hit_rank_out (hit_rank_ch[g+1]),
      .vic_out      (vic_ch[g+1]),
      .vic_rank_out (vic_rank_ch[g+1]),
      .nb_valid     (slot_valid[g+1]),
      .nb_ent       (slot_ent[g+1]),
      .nb_rank      (slot_rank[g+1]),
      .my_valid     (slot_valid[g]),
      .my_ent       (slot_ent[g]),
      .my_rank      (slot_rank[g])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_hit_nxt     = out_hit_r;
    out_frame_nxt   = out_frame_r;
    out_evicted_nxt = out_evicted_r;
    out_epage_nxt   = out_epage_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_en) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = en_r && is_lookup && hit_r;
          out_frame_nxt   = (en_r && is_lookup && hit_r) ? hit_frame_r : '0;
          out_evicted_nxt = evict;
          out_epage_nxt   = evict ? vic_page_r : '0;
          if (append) begin
            cnt_nxt = cnt_app + CW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      out_hit_r     <= 1'b0;
      out_frame_r   <= '0;
      out_evicted_r <= 1'b0;
      out_epage_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      out_hit_r     <= out_hit_nxt;
      out_frame_r   <= out_frame_nxt;
      out_evicted_r <= out_evicted_nxt;
      out_epage_r   <= out_epage_nxt;
    end
  end

  // hold the request and the compare results for the update cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_type_r      <= in_req_type;
      req_ent_r.pid   <= in_proc_id;
      req_ent_r.page  <= in_page_num;
      req_ent_r.frame <= in_frame_in;
      en_r            <= (capacity != '0);
      hit_r           <= hit_ch[ENTRIES].found;
      hit_frame_r     <= hit_ch[ENTRIES].frame;
      hit_rank_r      <= hit_rank_ch[ENTRIES];
      vic_page_r      <= vic_ch[ENTRIES].page;
      vic_rank_r      <= vic_rank_ch[ENTRIES];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame_out    = out_frame_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_epage_r;

endmodule

>>> hw/rtl/tlbfl_regs.sv
// Configuration register file behind the APB-style port.
module tlbfl_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tlbfl_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tlbfl_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tlbfl_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready,
  output logic                              mode,
  output logic [tlbfl_pkg::CAP_W-1:0]       capacity
);
  import tlbfl_pkg::*;

  logic             mode_r;
  logic [CAP_W-1:0] cap_r;
  logic             wr_en;
  logic             reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIFO;
      cap_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE: mode_r <= cfg_pwdata[0];
        REG_CAP:  cap_r  <= cfg_pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_MODE: cfg_prdata[0]       = mode_r;
      REG_CAP:  cfg_prdata[CAP_W-1:0] = cap_r;
      default: ;
    endcase
  end

  assign mode     = mode_r;
  assign capacity = cap_r;

endmodule

>>> hw/rtl/tlbfl_cell.sv
// One buffer slot: key compare, first-match and victim chains, shift and rank update.
module tlbfl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5,
  parameter int unsigned RW  = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tlbfl_pkg::cell_ctrl_t   ctrl,
  input  logic [RW-1:0]           thr,
  input  logic [RW-1:0]           promo_rank,
  input  logic [CW-1:0]           app_slot,
  // first-match and victim chains, running from slot 0 upward
  input  tlbfl_pkg::hit_chain_t   hit_in,
  input  logic [RW-1:0]           hit_rank_in,
  input  tlbfl_pkg::vic_chain_t   vic_in,
  input  logic [RW-1:0]           vic_rank_in,
  output tlbfl_pkg::hit_chain_t   hit_out,
  output logic [RW-1:0]           hit_rank_out,
  output tlbfl_pkg::vic_chain_t   vic_out,
  output logic [RW-1:0]           vic_rank_out,
  // slot contents handed down one place on removal
  input  logic                    nb_valid,
  input  tlbfl_pkg::entry_t       nb_ent,
  input  logic [RW-1:0]           nb_rank,
  output logic                    my_valid,
  output tlbfl_pkg::entry_t       my_ent,
  output logic [RW-1:0]           my_rank
);
  import tlbfl_pkg::*;

  localparam logic [CW-1:0] SLOT = CW'(IDX);

  logic          valid_r, valid_nxt;
  entry_t        ent_r, ent_nxt;
  logic [RW-1:0] rank_r, rank_nxt, rank_dec;
  logic          shift_r, hsel_r;
  logic          match, hit_here, vic_here;

  assign match    = valid_r && (ent_r.pid == ctrl.key_pid) && (ent_r.page == ctrl.key_page);
  assign hit_here = match && !hit_in.found;
  assign vic_here = valid_r && !vic_in.found &&
                    ((ctrl.mode == MODE_FIFO) || (rank_r == '0));

  always_comb begin
    hit_out      = hit_in;
    hit_rank_out = hit_rank_in;
    if (hit_here) begin
      hit_out.found = 1'b1;
      hit_out.frame = ent_r.frame;
      hit_rank_out  = rank_r;
    end
    vic_out      = vic_in;
    vic_rank_out = vic_rank_in;
    if (vic_here) begin
      vic_out.found = 1'b1;
      vic_out.page  = ent_r.page;
      vic_rank_out  = rank_r;
    end
  end

  // close the gap left by the promoted or removed entry
  assign rank_dec = (valid_r && ctrl.dec_en && (rank_r > thr)) ? rank_r - RW'(1) : rank_r;

  assign my_valid = valid_r;
  assign my_ent   = ent_r;
  assign my_rank  = rank_dec;

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    rank_nxt  = rank_r;
    if (ctrl.upd_en) begin
      rank_nxt = rank_dec;
      if (ctrl.evict && shift_r) begin
        valid_nxt = nb_valid;
        ent_nxt   = nb_ent;
        rank_nxt  = nb_rank;
      end
      if (ctrl.promote && hsel_r) begin
        rank_nxt = promo_rank;
      end
      if (ctrl.append && (app_slot == SLOT)) begin
        valid_nxt = 1'b1;
        ent_nxt   = ctrl.new_ent;
        rank_nxt  = app_slot[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    rank_r <= rank_nxt;
    if (ctrl.cmp_en) begin
      shift_r <= vic_in.found || vic_here;
      hsel_r  <= hit_here;
    end
  end

endmodule

>>> verif/tlb_fifo_lru_replacement_unit_tb.sv
// Self-checking testbench for the FIFO/LRU translation buffer top level.
`timescale 1ns / 100ps

module tlb_fifo_lru_replacement_unit_tb;
  import tlbfl_pkg::*;

  localparam int NUM_SLOTS  = DEF_ENTRIES;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_GOAL  = 2000;
  localparam int POOL_SIZE  = 8;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
  } tlb_result_t;

  // Translation buffer predictor plus the queue of results it has promised.
  class tlb_scoreboard;
    logic [PID_W-1:0]   tbl_pid   [NUM_SLOTS];
    logic [PAGE_W-1:0]  tbl_page  [NUM_SLOTS];
    logic [FRAME_W-1:0] tbl_frame [NUM_SLOTS];
    int                 tbl_rank  [NUM_SLOTS];
    int                 n_entries = 0;
    logic               mode      = MODE_FIFO;
    logic [CAP_W-1:0]   cap_reg   = '0;
    tlb_result_t        expected_q[$];
    int n_errors = 0, n_checked = 0, n_lookups = 0, n_adds = 0;
    int n_hits = 0, n_evictions = 0;

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_MODE) mode = value[0];
      else cap_reg = value[CAP_W-1:0];
    endfunction

    // Move slot s to the most recent rank.
    function void make_newest(int s);
      int r;
      r = tbl_rank[s];
      for (int i = 0; i < n_entries; i++)
        if (tbl_rank[i] > r) tbl_rank[i]--;
      tbl_rank[s] = n_entries - 1;
    endfunction

    // Remove slot s and close the gap, keeping insertion order.
    function void drop_entry(int s);
      int r;
      r = tbl_rank[s];
      for (int i = 0; i < n_entries; i++)
        if (tbl_rank[i] > r) tbl_rank[i]--;
      for (int i = s; i + 1 < n_entries; i++) begin
        tbl_pid[i]   = tbl_pid[i+1];
        tbl_page[i]  = tbl_page[i+1];
        tbl_frame[i] = tbl_frame[i+1];
        tbl_rank[i]  = tbl_rank[i+1];
      end
      n_entries--;
    endfunction

    function void note_request(logic req, logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                               logic [FRAME_W-1:0] frame);
      tlb_result_t res;
      int          lim;
      int          victim;
      res = '0;
      lim = (cap_reg > NUM_SLOTS) ? NUM_SLOTS : int'(cap_reg);
      if (req == REQ_LOOKUP) n_lookups++;
      else n_adds++;
      if (lim != 0) begin
        if (req == REQ_LOOKUP) begin
          for (int i = 0; i < n_entries; i++) begin
            if (tbl_pid[i] == pid && tbl_page[i] == page) begin
              res.hit   = 1'b1;
              res.frame = tbl_frame[i];
              if (mode == MODE_LRU) make_newest(i);
              break;
            end
          end
        end else begin
          if (n_entries >= lim && n_entries > 0) begin
            victim = 0;
            if (mode == MODE_LRU) begin
              for (int i = 0; i < n_entries; i++)
                if (tbl_rank[i] == 0) begin
                  victim = i;
                  break;
                end
            end
            res.evicted      = 1'b1;
            res.evicted_page = tbl_page[victim];
            drop_entry(victim);
          end
          if (n_entries < NUM_SLOTS) begin
            tbl_pid[n_entries]   = pid;
            tbl_page[n_entries]  = page;
            tbl_frame[n_entries] = frame;
            tbl_rank[n_entries]  = n_entries;
            n_entries++;
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      n_errors++;
    endtask

    task check_result(logic hit, logic [FRAME_W-1:0] frame, logic evicted,
                      logic [PAGE_W-1:0] evicted_page);
      tlb_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (want.hit) n_hits++;
      if (want.evicted) n_evictions++;
      if (hit !== want.hit)
        report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
      if (frame !== want.frame)
        report_mismatch($sformatf("frame_out %h, want %h", frame, want.frame));
      if (evicted !== want.evicted)
        report_mismatch($sformatf("evicted %b, want %b", evicted, want.evicted));
      if (evicted_page !== want.evicted_page)
        report_mismatch($sformatf("evicted_page %h, want %h", evicted_page,
                                  want.evicted_page));
    endtask
  endclass

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic                  in_req_type      = REQ_LOOKUP;
  logic [PID_W-1:0]      in_proc_id       = '0;
  logic [PAGE_W-1:0]     in_page_num      = '0;
  logic [FRAME_W-1:0]    in_frame_in      = '0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic                  out_hit;
  logic [FRAME_W-1:0]    out_frame_out;
  logic                  out_evicted;
  logic [PAGE_W-1:0]     out_evicted_page;
  logic                  cfg_psel         = 1'b0;
  logic                  cfg_penable      = 1'b0;
  logic                  cfg_pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr        = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata       = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tlb_scoreboard    sb;
  int               burst_left  = 4;
  int               idle_cycles = 0;
  int               pat_age     = 0;
  logic [15:0]      ready_pat   = 16'hFFFF;
  logic [PID_W-1:0] pool_pid  [POOL_SIZE];
  logic [PAGE_W-1:0] pool_page [POOL_SIZE];

  tlb_fifo_lru_replacement_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_proc_id       (in_proc_id),
    .in_page_num      (in_page_num),
    .in_frame_in      (in_frame_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_frame_out    (out_frame_out),
    .out_evicted      (out_evicted),
    .out_evicted_page (out_evicted_page),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #6 clk = ~clk;

  // Receiver: rotate a stall pattern, pick a fresh one every so often.
  always @(posedge clk) begin
    if (pat_age == 0) begin
      pat_age <= $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: ready_pat <= 16'hFFFF;
        1: ready_pat <= 16'($urandom()) | 16'h0001;
        2: ready_pat <= 16'($urandom() | $urandom()) | 16'h0001;
        default: ready_pat <= 16'h0001 << $urandom_range(0, 15);
      endcase
    end else begin
      pat_age   <= pat_age - 1;
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    end
    out_ready <= ready_pat[0];
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_hit, out_frame_out, out_evicted, out_evicted_page);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAIL tlb_fifo_lru_replacement_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold the transaction until accepted, then note it and maybe start a gap.
  task automatic send_item(input logic req, input logic [PID_W-1:0] pid,
                           input logic [PAGE_W-1:0] page, input logic [FRAME_W-1:0] frame);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_proc_id  <= pid;
    in_page_num <= page;
    in_frame_in <= frame;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, pid, page, frame);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait until every result is back and the row has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int   phase;
    int   counted;
    int   phase_len;
    int   roll;
    int   slot;
    int   cap_sel;
    logic mode_sel;

    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset: everything misses, adds are dropped.
    send_item(REQ_LOOKUP, '0, '0, '1);
    send_item(REQ_ADD, '1, '1, '1);
    wait_idle();

    // FIFO, two entries: hits, partial key match, oldest-first eviction.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_FIFO));
    write_reg(REG_CAP, 2);
    send_item(REQ_ADD, '0, '0, '0);
    send_item(REQ_ADD, '1, '1, '1);
    send_item(REQ_LOOKUP, '0, '0, '1);
    send_item(REQ_LOOKUP, '1, '1, '0);
    send_item(REQ_LOOKUP, '0, '1, '0);
    send_item(REQ_ADD, 16'h1234, 20'h55555, 20'hAAAAA);
    send_item(REQ_LOOKUP, '0, '0, '0);
    wait_idle();

    // LRU: a hit protects the older entry from eviction.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_LRU));
    send_item(REQ_LOOKUP, '1, '1, '0);
    send_item(REQ_ADD, 16'h8000, 20'h80000, 20'h7FFFF);
    send_item(REQ_LOOKUP, 16'h1234, 20'h55555, '0);
    send_item(REQ_LOOKUP, '1, '1, '0);
    wait_idle();

    // Capacity below the current count: adds replace, count holds.
    write_reg(REG_CAP, 1);
    send_item(REQ_ADD, 16'h0001, 20'h00001, 20'h00001);
    send_item(REQ_LOOKUP, 16'h0001, 20'h00001, '0);
    wait_idle();

    // Saturated capacity and duplicate keys: first inserted copy wins.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_FIFO));
    write_reg(REG_CAP, 31);
    send_item(REQ_ADD, 16'hBEEF, 20'hCAFE0, 20'h11111);
    send_item(REQ_ADD, 16'hBEEF, 20'hCAFE0, 20'h22222);
    send_item(REQ_LOOKUP, 16'hBEEF, 20'hCAFE0, '0);
    wait_idle();

    counted = 0;
    phase   = 0;
    while (counted < ITEM_GOAL) begin
      case (phase)
        0: cap_sel = 16;
        1: cap_sel = 1;
        2: cap_sel = 31;
        3: cap_sel = 0;
        4: cap_sel = 17;
        5: cap_sel = 3;
        default: begin
          roll = $urandom_range(0, 9);
          cap_sel = (roll == 0) ? 31 : (roll == 1) ? 0 : (roll == 2) ? 1
                  : $urandom_range(2, 16);
        end
      endcase
      mode_sel = (phase < 6) ? ((phase % 2) ? MODE_LRU : MODE_FIFO)
                             : logic'($urandom_range(0, 1));
      write_reg(REG_MODE, CFG_DATA_W'(mode_sel));
      write_reg(REG_CAP, cap_sel);

      // Keys that differ from a base key in one field only stress the compare.
      pool_pid[0]  = 16'($urandom());
      pool_page[0] = 20'($urandom());
      for (int k = 1; k < POOL_SIZE; k++) begin
        roll = $urandom_range(0, 2);
        pool_pid[k]  = (roll == 1) ? pool_pid[0] ^ (16'h1 << $urandom_range(0, 15))
                     : (roll == 2) ? 16'($urandom()) : pool_pid[0];
        pool_page[k] = (roll == 0) ? pool_page[0] ^ (20'h1 << $urandom_range(0, 19))
                     : 20'($urandom());
      end

      phase_len = (cap_sel == 0) ? 30 : $urandom_range(120, 220);
      for (int n = 0; n < phase_len; n++) begin
        roll = $urandom_range(0, 99);
        slot = $urandom_range(0, POOL_SIZE - 1);
        if (roll < 40) begin
          if ($urandom_range(0, 9) < 7)
            send_item(REQ_ADD, pool_pid[slot], pool_page[slot], 20'($urandom()));
          else
            send_item(REQ_ADD, 16'($urandom()), 20'($urandom()), 20'($urandom()));
        end else if (roll < 75 && sb.n_entries > 0) begin
          slot = $urandom_range(0, sb.n_entries - 1);
          send_item(REQ_LOOKUP, sb.tbl_pid[slot], sb.tbl_page[slot], 20'($urandom()));
        end else if (roll < 90) begin
          send_item(REQ_LOOKUP, pool_pid[slot], pool_page[slot], 20'($urandom()));
        end else begin
          send_item(REQ_LOOKUP, 16'($urandom()), 20'($urandom()), 20'($urandom()));
        end
      end
      if (cap_sel != 0) counted += phase_len;
      wait_idle();
      phase++;
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d results over %0d random phases plus directed cases.",
             sb.n_checked, phase);
    $display("%0d lookups with %0d hits, %0d adds with %0d evictions, %0d mismatches.",
             sb.n_lookups, sb.n_hits, sb.n_adds, sb.n_evictions, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASS tlb_fifo_lru_replacement_unit");
    end else begin
      $display("FAIL tlb_fifo_lru_replacement_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tlbfl_pkg.sv
hw/rtl/tlbfl_regs.sv
hw/rtl/tlbfl_cell.sv
hw/rtl/tlb_fifo_lru_replacement_unit.sv
verif/tlb_fifo_lru_replacement_unit_tb.sv
